@@ rtl/cht_pkg.sv @@
// Package: shared types and codes for the chained hash table.
package cht_pkg;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_SEARCH = 2'd1,
		CMD_DELETE = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_INVALID   = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLR,
		S_HEAD,
		S_HEAD_W,
		S_FREE,
		S_INS,
		S_RD,
		S_CMP,
		S_UNLINK,
		S_DONE
	} state_t;

endpackage

@@ rtl/chained_hash_table.sv @@
// Top level: separate-chaining hash table with a small sequencer over node memories.
//
//  channel  | signals                                  | dir
//  request  | start, busy (out), command, key,         | in
//           | record_index, batch_last                 |
//  result   | done, status, found_index, last_echo     | out
//
// Insert: reads the bucket head, scans the used bits from node 0 up to the lowest free node, then links it in.
// Search/delete: reads the bucket head, then reads and compares each chain node in turn;
// a delete then unlinks the match. An empty bucket ends after the head read; a zero key answers at once.
// Clear: sweeps the head memory one bucket per cycle.
// After reset a clearing pass runs with busy high.
// Results show for one cycle on done; the receiver cannot stall them.
module chained_hash_table #(
	parameter int BUCKETS = 64,
	parameter int NODES   = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  command,
	input  logic [30:0] key,
	input  logic [15:0] record_index,
	input  logic        batch_last,
	output logic        done,
	output logic [1:0]  status,
	output logic [15:0] found_index,
	output logic        last_echo
);
	localparam int NW = $clog2(NODES);
	localparam int PW = NW + 1;
	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int CW = $clog2(BUCKETS + 1);
	localparam logic [PW-1:0] NULLP = PW'(NODES);

	cht_pkg::state_t state_q, state_d;

	logic [PW-1:0] head_mem [BUCKETS];
	logic [30:0]   key_mem  [NODES];
	logic [15:0]   rec_mem  [NODES];
	logic [PW-1:0] link_mem [NODES];

	logic [1:0]    cmd_q;
	logic [30:0]   key_q;
	logic [15:0]   rec_q;
	logic          last_q;
	logic [BW-1:0] bucket_q;
	logic [CW-1:0] cnt_q;
	logic [PW-1:0] cur_q, prev_q, head_q;
	logic [30:0]   nkey_q;
	logic [15:0]   nrec_q;
	logic [PW-1:0] nlink_q;
	logic [PW:0]   steps_q;
	logic [1:0]    status_q;
	logic [15:0]   found_q;
	logic          done_q;

	logic          probe_used;

	function automatic logic [BW-1:0] bucket_bits(input logic [30:0] k);
		return BW'(k % BUCKETS);
	endfunction

	cht_free_scan #(.NODES(NODES)) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.clear     (state_q == cht_pkg::S_CLR && cmd_q == cht_pkg::CMD_CLEAR
		            && cnt_q == '0),
		.set_en    (state_q == cht_pkg::S_INS),
		.clr_en    (state_q == cht_pkg::S_UNLINK),
		.set_idx   (cur_q[NW-1:0]),
		.clr_idx   (cur_q[NW-1:0]),
		.probe     (cur_q[NW-1:0]),
		.probe_used(probe_used)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			cht_pkg::S_IDLE: begin
				if (start) begin
					if (command == cht_pkg::CMD_CLEAR) state_d = cht_pkg::S_CLR;
					else if (key == '0) state_d = cht_pkg::S_DONE;
					else state_d = cht_pkg::S_HEAD;
				end
			end
			cht_pkg::S_CLR: if (cnt_q == CW'(BUCKETS - 1)) state_d = cht_pkg::S_DONE;
			cht_pkg::S_HEAD: begin
				if (cmd_q == cht_pkg::CMD_INSERT) state_d = cht_pkg::S_FREE;
				else state_d = cht_pkg::S_HEAD_W;
			end
			cht_pkg::S_HEAD_W: begin
				if (cur_q == NULLP || cur_q > NULLP) state_d = cht_pkg::S_DONE;
				else state_d = cht_pkg::S_RD;
			end
			cht_pkg::S_FREE: begin
				if (cur_q == NULLP) state_d = cht_pkg::S_DONE;
				else if (!probe_used) state_d = cht_pkg::S_INS;
			end
			cht_pkg::S_INS: state_d = cht_pkg::S_DONE;
			cht_pkg::S_RD: state_d = cht_pkg::S_CMP;
			cht_pkg::S_CMP: begin
				if (nkey_q == key_q) begin
					if (cmd_q == cht_pkg::CMD_DELETE) state_d = cht_pkg::S_UNLINK;
					else state_d = cht_pkg::S_DONE;
				end else if (nlink_q >= NULLP || steps_q == (PW+1)'(NODES - 1)) begin
					state_d = cht_pkg::S_DONE;
				end else begin
					state_d = cht_pkg::S_HEAD_W;
				end
			end
			cht_pkg::S_UNLINK: state_d = cht_pkg::S_DONE;
			cht_pkg::S_DONE: state_d = cht_pkg::S_IDLE;
			default: state_d = cht_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != cht_pkg::S_IDLE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cht_pkg::S_CLR;
			cmd_q   <= cht_pkg::CMD_SEARCH;
			cnt_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			// the clearing pass after reset ends without a result
			done_q  <= (state_q == cht_pkg::S_DONE)
			           && !(cnt_q == CW'(BUCKETS) && cmd_q == cht_pkg::CMD_SEARCH);
			if (state_q == cht_pkg::S_IDLE && start) begin
				cmd_q <= command;
				cnt_q <= '0;
			end else if (state_q == cht_pkg::S_CLR) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			cht_pkg::S_IDLE: begin
				key_q    <= key;
				rec_q    <= record_index;
				last_q   <= batch_last;
				bucket_q <= bucket_bits(key);
				status_q <= (command != cht_pkg::CMD_CLEAR && key == '0) ?
				            cht_pkg::ST_INVALID : cht_pkg::ST_OK;
				found_q  <= '0;
				steps_q  <= '0;
				prev_q   <= NULLP;
			end
			cht_pkg::S_CLR: head_mem[cnt_q[BW-1:0]] <= NULLP;
			cht_pkg::S_HEAD: begin
				head_q <= head_mem[bucket_q];
				cur_q  <= (cmd_q == cht_pkg::CMD_INSERT) ? '0 : head_mem[bucket_q];
			end
			cht_pkg::S_HEAD_W: begin
				if (cur_q >= NULLP) status_q <= cht_pkg::ST_NOT_FOUND;
			end
			cht_pkg::S_FREE: begin
				if (cur_q == NULLP) status_q <= cht_pkg::ST_FULL;
				else if (probe_used) cur_q <= cur_q + 1'b1;
			end
			cht_pkg::S_INS: begin
				key_mem[cur_q[NW-1:0]]  <= key_q;
				rec_mem[cur_q[NW-1:0]]  <= rec_q;
				link_mem[cur_q[NW-1:0]] <= head_q;
				head_mem[bucket_q]      <= cur_q;
			end
			cht_pkg::S_RD: begin
				nkey_q  <= key_mem[cur_q[NW-1:0]];
				nrec_q  <= rec_mem[cur_q[NW-1:0]];
				nlink_q <= link_mem[cur_q[NW-1:0]];
			end
			cht_pkg::S_CMP: begin
				if (nkey_q == key_q) begin
					if (cmd_q == cht_pkg::CMD_SEARCH) found_q <= nrec_q;
				end else begin
					if (nlink_q >= NULLP || steps_q == (PW+1)'(NODES - 1))
						status_q <= cht_pkg::ST_NOT_FOUND;
					prev_q  <= cur_q;
					cur_q   <= nlink_q;
					steps_q <= steps_q + 1'b1;
				end
			end
			cht_pkg::S_UNLINK: begin
				if (prev_q == NULLP) head_mem[bucket_q] <= nlink_q;
				else link_mem[prev_q[NW-1:0]] <= nlink_q;
			end
			default: ;
		endcase
	end

	assign done        = done_q;
	assign status      = status_q;
	assign found_index = found_q;
	assign last_echo   = last_q;
endmodule

@@ rtl/cht_free_scan.sv @@
// Free-node tracker: holds a used bit per node and reports the bit at the probe index; the caller steps the probe.
module cht_free_scan #(
	parameter int NODES = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     clear,
	input  logic                     set_en,
	input  logic                     clr_en,
	input  logic [$clog2(NODES)-1:0] set_idx,
	input  logic [$clog2(NODES)-1:0] clr_idx,
	input  logic [$clog2(NODES)-1:0] probe,
	output logic                     probe_used
);
	logic [NODES-1:0] used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (clear) begin
			used_q <= '0;
		end else begin
			if (set_en) used_q[set_idx] <= 1'b1;
			if (clr_en) used_q[clr_idx] <= 1'b0;
		end
	end

	assign probe_used = used_q[probe];
endmodule

@@ rtl/cht_checker.sv @@
// Port checker for the chained hash table, bound to the top level.
module cht_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [1:0]  status,
	input logic [15:0] found_index
);
	a_busy_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("busy not raised after request");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result strobe longer than one cycle");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");
	a_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != cht_pkg::ST_OK |-> found_index == '0)
		else $error("found_index set on failure");
endmodule

bind chained_hash_table cht_checker u_cht_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.status(status), .found_index(found_index)
);

@@ tb/sv/tb.sv @@
// Testbench for chained_hash_table: directed and random requests against an internal table model.
`timescale 1ns / 100ps
module tb;

	localparam int BUCKETS = 64;
	localparam int NODES   = 256;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  command = cht_pkg::CMD_CLEAR;
	logic [30:0] key = '0;
	logic [15:0] record_index = '0;
	logic        batch_last = 1'b0;
	logic        done;
	logic [1:0]  status;
	logic [15:0] found_index;
	logic        last_echo;

	typedef struct packed {
		logic [1:0]  st;
		logic [15:0] idx;
		logic        last;
	} answer_t;

	// table model
	int unsigned mdl_head [BUCKETS];
	logic [30:0] mdl_key  [NODES];
	logic [15:0] mdl_rec  [NODES];
	int unsigned mdl_link [NODES];
	bit          mdl_used [NODES];

	answer_t     answer_q [$];
	int          mismatches = 0;
	logic [30:0] key_pool [16];

	chained_hash_table #(.BUCKETS(BUCKETS), .NODES(NODES)) i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .key(key), .record_index(record_index),
		.batch_last(batch_last), .done(done), .status(status),
		.found_index(found_index), .last_echo(last_echo)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void table_clear();
		for (int b = 0; b < BUCKETS; b++) mdl_head[b] = NODES;
		for (int n = 0; n < NODES; n++) mdl_used[n] = 1'b0;
	endfunction

	function automatic answer_t table_apply(logic [1:0] cmd, logic [30:0] k,
			logic [15:0] rec, logic last);
		answer_t a;
		int unsigned bkt, cur, prev, steps, node;
		a = '{st: cht_pkg::ST_OK, idx: '0, last: last};
		bkt = k % BUCKETS;
		if (cmd == cht_pkg::CMD_CLEAR) begin
			table_clear();
		end else if (k == '0) begin
			a.st = cht_pkg::ST_INVALID;
		end else if (cmd == cht_pkg::CMD_INSERT) begin
			node = NODES;
			for (int n = NODES - 1; n >= 0; n--) if (!mdl_used[n]) node = n;
			if (node == NODES) begin
				a.st = cht_pkg::ST_FULL;
			end else begin
				mdl_key[node] = k;
				mdl_rec[node] = rec;
				mdl_link[node] = mdl_head[bkt];
				mdl_used[node] = 1'b1;
				mdl_head[bkt] = node;
			end
		end else begin
			cur = mdl_head[bkt];
			prev = NODES;
			steps = 0;
			while (cur < NODES && steps < NODES && mdl_key[cur] != k) begin
				prev = cur;
				cur = mdl_link[cur];
				steps++;
			end
			if (cur >= NODES || steps >= NODES) begin
				a.st = cht_pkg::ST_NOT_FOUND;
			end else if (cmd == cht_pkg::CMD_SEARCH) begin
				a.idx = mdl_rec[cur];
			end else begin
				if (prev == NODES) mdl_head[bkt] = mdl_link[cur];
				else mdl_link[prev] = mdl_link[cur];
				mdl_used[cur] = 1'b0;
			end
		end
		return a;
	endfunction

	task automatic idle_gap();
		int r, n;
		r = $urandom_range(0, 99);
		n = (r < 40) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// start stays high into the next request when no gap follows
	task automatic send_request(logic [1:0] cmd, logic [30:0] k, logic [15:0] rec,
			logic last, bit gaps = 1'b1);
		start <= 1'b1;
		command <= cmd;
		key <= k;
		record_index <= rec;
		batch_last <= last;
		@(posedge clk);
		while (busy) @(posedge clk);
		answer_q.push_back(table_apply(cmd, k, rec, last));
		if (gaps) idle_gap();
	endtask

	always @(posedge clk) begin
		answer_t e;
		if (arst_n && done) begin
			if (answer_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result status=%0d", status);
			end else begin
				e = answer_q.pop_front();
				if (status !== e.st || found_index !== e.idx || last_echo !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp st=%0d idx=%h last=%b got st=%0d idx=%h last=%b",
							e.st, e.idx, e.last, status, found_index, last_echo);
				end
			end
		end
	end

	task automatic test_invalid_and_empty();
		send_request(cht_pkg::CMD_SEARCH, 31'd5, 16'h0, 1'b0);
		send_request(cht_pkg::CMD_DELETE, 31'd5, 16'h0, 1'b1);
		send_request(cht_pkg::CMD_INSERT, 31'd0, 16'hFFFF, 1'b1);
		send_request(cht_pkg::CMD_SEARCH, 31'd0, 16'h0, 1'b0);
		send_request(cht_pkg::CMD_DELETE, 31'd0, 16'h0, 1'b0);
	endtask

	task automatic test_duplicates_and_chain();
		send_request(cht_pkg::CMD_INSERT, 31'h7FFFFFFF, 16'hFFFF, 1'b0);
		send_request(cht_pkg::CMD_INSERT, 31'h7FFFFFFF, 16'h1234, 1'b1);
		send_request(cht_pkg::CMD_INSERT, 31'd63, 16'h0000, 1'b0);
		send_request(cht_pkg::CMD_INSERT, 31'd127, 16'hAAAA, 1'b0);
		send_request(cht_pkg::CMD_SEARCH, 31'h7FFFFFFF, 16'h0, 1'b1);
		send_request(cht_pkg::CMD_SEARCH, 31'd63, 16'h0, 1'b0);
		send_request(cht_pkg::CMD_DELETE, 31'h7FFFFFFF, 16'h0, 1'b0);
		send_request(cht_pkg::CMD_SEARCH, 31'h7FFFFFFF, 16'h0, 1'b0);
		send_request(cht_pkg::CMD_DELETE, 31'd63, 16'h0, 1'b0);
		send_request(cht_pkg::CMD_SEARCH, 31'd127, 16'h0, 1'b1);
		send_request(cht_pkg::CMD_SEARCH, 31'd191, 16'h0, 1'b0);
		send_request(cht_pkg::CMD_CLEAR, 31'h55555555, 16'h5555, 1'b1);
		send_request(cht_pkg::CMD_SEARCH, 31'd127, 16'h0, 1'b0);
	endtask

	task automatic test_pool_full();
		// keys spread over buckets keep chains short
		for (int n = 0; n <= NODES; n++)
			send_request(cht_pkg::CMD_INSERT, 31'(n + 1), 16'(n * 7), 1'(n), 1'b0);
		send_request(cht_pkg::CMD_DELETE, 31'd100, 16'h0, 1'b0);
		send_request(cht_pkg::CMD_INSERT, 31'd9999, 16'hBEEF, 1'b1);
		send_request(cht_pkg::CMD_SEARCH, 31'd9999, 16'h0, 1'b0);
		send_request(cht_pkg::CMD_CLEAR, 31'd0, 16'h0, 1'b0);
	endtask

	task automatic test_random();
		int r;
		logic [1:0] cmd;
		logic [30:0] k;
		for (int i = 0; i < 16; i++) key_pool[i] = 31'($urandom());
		for (int i = 0; i < 820; i++) begin
			r = $urandom_range(0, 99);
			cmd = (r < 45) ? cht_pkg::CMD_INSERT : (r < 75) ? cht_pkg::CMD_SEARCH
				: (r < 98) ? cht_pkg::CMD_DELETE : cht_pkg::CMD_CLEAR;
			r = $urandom_range(0, 99);
			k = (r < 75) ? key_pool[$urandom_range(0, 15)] : (r < 97) ? 31'($urandom())
				: 31'd0;
			send_request(cmd, k, 16'($urandom()), 1'($urandom()));
		end
	endtask

	initial begin
		table_clear();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_invalid_and_empty();
		test_duplicates_and_chain();
		test_pool_full();
		test_random();
		start <= 1'b0;
		while (answer_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && answer_q.size() == 0) $display("end of test: clean");
		else $display("end of test: mismatches");
		$finish;
	end

	initial begin
		#20000000;
		$display("end of test: mismatches");
		$finish;
	end
endmodule
